/* hdl/pev_pkg.sv */
package pev_pkg;

    localparam int ADDR_W   = 5;
    localparam int NSTAGE   = 18;
    localparam int DIV_FIRST = 1;
    localparam int DIV_LAST  = 8;
    localparam int DIV_PER   = 2;
    localparam int BLEND_ST  = 9;
    localparam int SCALE_ST  = 10;
    localparam int MOD_FIRST = 11;
    localparam int MOD_LAST  = 16;
    localparam int MOD_PER   = 3;
    localparam int FINAL_ST  = 17;
    localparam int IDX_W     = 17;
    localparam int MOD_TAIL  = IDX_W - (MOD_LAST - MOD_FIRST) * MOD_PER;

    typedef enum logic [2:0] {
        REG_GRAVITY,
        REG_COLOR_START,
        REG_COLOR_END,
        REG_ATLAS_ENABLE,
        REG_ATLAS_COLUMNS,
        REG_ATLAS_ROWS,
        REG_ANIM_SPEED
    } reg_idx_t;

    typedef struct packed {
        logic signed [31:0] gravity;
        logic [31:0]        color_start;
        logic [31:0]        color_end;
        logic               atlas_enable;
        logic [4:0]         atlas_columns;
        logic [4:0]         atlas_rows;
        logic [15:0]        anim_speed;
    } cfg_t;

    typedef struct packed {
        logic [31:0]        step_time;
        logic [31:0]        age_in;
        logic [31:0]        lifetime;
        logic signed [31:0] pos_x_in;
        logic signed [31:0] pos_y_in;
        logic signed [31:0] pos_z_in;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y_in;
        logic signed [31:0] vel_z;
        logic signed [31:0] angle_in;
        logic signed [31:0] spin_rate;
    } item_t;

    typedef struct packed {
        logic               active;
        logic [31:0]        age_out;
        logic signed [31:0] pos_x_out;
        logic signed [31:0] pos_y_out;
        logic signed [31:0] pos_z_out;
        logic signed [31:0] vel_y_out;
        logic signed [31:0] angle_out;
        logic [7:0]         color_red;
        logic [7:0]         color_green;
        logic [7:0]         color_blue;
        logic [7:0]         color_alpha;
        logic [7:0]         frame_index;
    } result_t;

    typedef struct packed {
        logic               live;
        logic               full;
        logic [31:0]        dt;
        logic [31:0]        age;
        logic [31:0]        life;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic signed [31:0] vy;
        logic signed [31:0] ang;
        logic signed [47:0] prod_g;
        logic signed [47:0] prod_x;
        logic signed [47:0] prod_z;
        logic signed [47:0] prod_s;
        logic signed [47:0] prod_y;
        logic [31:0]        rem;
        logic [15:0]        quot;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [7:0]         alpha;
        logic [24:0]        rt;
        logic [IDX_W-1:0]   idx;
        logic [7:0]         mrem;
    } work_t;

    // floor(a * b / 2^16), a signed, b unsigned
    function automatic logic signed [47:0] mul_q16(input logic signed [31:0] a,
                                                   input logic [31:0] b);
        logic signed [32:0] bs;
        logic signed [64:0] p;
        bs = {1'b0, b};
        p  = a * bs;
        return p[63:16];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
        if (v > 49'sh0_7FFF_FFFF)
            return 32'sh7FFF_FFFF;
        if (v < -49'sh0_8000_0000)
            return -32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic logic [4:0] clamp_dim(input logic [4:0] d);
        if (d == 5'd0)
            return 5'd1;
        if (d > 5'd16)
            return 5'd16;
        return d;
    endfunction

    function automatic logic [8:0] frame_total(input cfg_t c);
        return 9'(clamp_dim(c.atlas_columns)) * 9'(clamp_dim(c.atlas_rows));
    endfunction

    function automatic logic [7:0] blend8(input logic [7:0] s, input logic [7:0] e,
                                          input logic [16:0] r, input logic [16:0] inv);
        logic [24:0] acc;
        acc = 25'(s) * 25'(inv) + 25'(e) * 25'(r) + 25'd32768;
        return acc[23:16];
    endfunction

    // first stage: age, liveness, the four products that need only input fields
    function automatic work_t front(input item_t i, input cfg_t c);
        work_t       o;
        logic [32:0] sum;
        logic [31:0] na;
        o    = '0;
        sum  = {1'b0, i.age_in} + {1'b0, i.step_time};
        na   = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        o.live   = (i.age_in < i.lifetime);
        o.age    = o.live ? na : i.age_in;
        o.full   = (na >= i.lifetime);
        o.dt     = i.step_time;
        o.life   = i.lifetime;
        o.rem    = na;
        o.px     = i.pos_x_in;
        o.py     = i.pos_y_in;
        o.pz     = i.pos_z_in;
        o.vy     = i.vel_y_in;
        o.ang    = i.angle_in;
        o.prod_g = mul_q16(c.gravity, i.step_time);
        o.prod_x = mul_q16(i.vel_x, i.step_time);
        o.prod_z = mul_q16(i.vel_z, i.step_time);
        o.prod_s = mul_q16(i.spin_rate, i.step_time);
        return o;
    endfunction

    function automatic work_t stage_op(input int k, input work_t w, input cfg_t c);
        work_t       o;
        logic [32:0] t;
        logic [16:0] r;
        logic [16:0] inv;
        logic [41:0] sp;
        logic [8:0]  m;
        logic [8:0]  tot;
        int          n;
        int          j;
        o   = w;
        tot = frame_total(c);
        if (k == 1 && w.live)
        begin
            o.vy  = sat32(49'(w.vy) + 49'(w.prod_g));
            o.px  = sat32(49'(w.px) + 49'(w.prod_x));
            o.pz  = sat32(49'(w.pz) + 49'(w.prod_z));
            o.ang = w.ang + w.prod_s[31:0];
        end
        if (k == 2)
            o.prod_y = mul_q16(w.vy, w.dt);
        if (k == 3 && w.live)
            o.py = sat32(49'(w.py) + 49'(w.prod_y));
        // ratio divider: two restoring steps per stage
        if (k >= DIV_FIRST && k <= DIV_LAST)
        begin
            for (j = 0; j < DIV_PER; j++)
            begin
                t = {o.rem, 1'b0};
                if (t >= {1'b0, w.life})
                begin
                    o.rem  = 32'(t - {1'b0, w.life});
                    o.quot = {o.quot[14:0], 1'b1};
                end
                else
                begin
                    o.rem  = t[31:0];
                    o.quot = {o.quot[14:0], 1'b0};
                end
            end
        end
        if (k == BLEND_ST)
        begin
            r       = w.full ? 17'h10000 : {1'b0, w.quot};
            inv     = 17'h10000 - r;
            o.red   = blend8(c.color_start[31:24], c.color_end[31:24], r, inv);
            o.green = blend8(c.color_start[23:16], c.color_end[23:16], r, inv);
            o.blue  = blend8(c.color_start[15:8], c.color_end[15:8], r, inv);
            o.alpha = blend8(c.color_start[7:0], c.color_end[7:0], r, inv);
            o.rt    = 25'(r) * 25'(tot);
        end
        if (k == SCALE_ST)
        begin
            sp     = 42'(w.rt) * 42'(c.anim_speed);
            o.idx  = sp[IDX_W+23:24];
            o.mrem = '0;
        end
        // frame modulo: shift in one index bit per step
        if (k >= MOD_FIRST && k <= MOD_LAST)
        begin
            n = (k == MOD_LAST) ? MOD_TAIL : MOD_PER;
            for (j = 0; j < MOD_PER; j++)
            begin
                if (j < n)
                begin
                    m     = {o.mrem, o.idx[IDX_W-1]};
                    o.idx = {o.idx[IDX_W-2:0], 1'b0};
                    if (m >= tot)
                        m = m - tot;
                    o.mrem = m[7:0];
                end
            end
        end
        if (k == FINAL_ST)
        begin
            if (!w.live || !c.atlas_enable)
                o.mrem = '0;
            if (!w.live)
            begin
                o.red   = '0;
                o.green = '0;
                o.blue  = '0;
                o.alpha = '0;
            end
        end
        return o;
    endfunction

    function automatic result_t to_result(input work_t w);
        result_t o;
        o.active      = w.live;
        o.age_out     = w.age;
        o.pos_x_out   = w.px;
        o.pos_y_out   = w.py;
        o.pos_z_out   = w.pz;
        o.vel_y_out   = w.vy;
        o.angle_out   = w.ang;
        o.color_red   = w.red;
        o.color_green = w.green;
        o.color_blue  = w.blue;
        o.color_alpha = w.alpha;
        o.frame_index = w.mrem;
        return o;
    endfunction

endpackage

/* hdl/pev_cfg.sv */
module pev_cfg (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [pev_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output pev_pkg::cfg_t              cfg
);
    import pev_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_GRAVITY:       cfg_next.gravity       = pwdata;
                REG_COLOR_START:   cfg_next.color_start   = pwdata;
                REG_COLOR_END:     cfg_next.color_end     = pwdata;
                REG_ATLAS_ENABLE:  cfg_next.atlas_enable  = pwdata[0];
                REG_ATLAS_COLUMNS: cfg_next.atlas_columns = pwdata[4:0];
                REG_ATLAS_ROWS:    cfg_next.atlas_rows    = pwdata[4:0];
                REG_ANIM_SPEED:    cfg_next.anim_speed    = pwdata[15:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_GRAVITY:       prdata = cfg_reg.gravity;
            REG_COLOR_START:   prdata = cfg_reg.color_start;
            REG_COLOR_END:     prdata = cfg_reg.color_end;
            REG_ATLAS_ENABLE:  prdata = 32'(cfg_reg.atlas_enable);
            REG_ATLAS_COLUMNS: prdata = 32'(cfg_reg.atlas_columns);
            REG_ATLAS_ROWS:    prdata = 32'(cfg_reg.atlas_rows);
            REG_ANIM_SPEED:    prdata = 32'(cfg_reg.anim_speed);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gravity       <= '0;
            cfg_reg.color_start   <= 32'hFFFF_FFFF;
            cfg_reg.color_end     <= '0;
            cfg_reg.atlas_enable  <= 1'b0;
            cfg_reg.atlas_columns <= 5'd1;
            cfg_reg.atlas_rows    <= 5'd1;
            cfg_reg.anim_speed    <= 16'd256;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* hdl/pev_pipe.sv */
module pev_pipe (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           up_valid,
    output logic           up_ready,
    input  pev_pkg::work_t up_data,
    output logic           down_valid,
    input  logic           down_ready,
    output pev_pkg::work_t down_data
);
    import pev_pkg::*;

    logic  valid_reg;
    work_t data_reg;

    // take a new item when empty or when the held one moves on
    assign up_ready   = !valid_reg || down_ready;
    assign down_valid = valid_reg;
    assign down_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            data_reg <= up_data;
    end

endmodule

/* hdl/particle_euler_update_top.sv */
// Particle Euler update: one explicit integration step per particle record.
// Input channel item_valid/item_ready/item carries one record and dt; output
// channel result_valid/result_ready/result returns the updated record, its
// blended color and atlas frame. Registers (gravity, colors, atlas setup,
// animation speed) sit behind an APB port at byte address 4*index.
// Throughput: one item per cycle unless result_ready stalls the pipeline. The
// pipeline has 18 stages; the life ratio divider spends eight of them at two
// quotient bits each, and the atlas frame modulo spends six at three index
// bits each (two in the last one).
// Every stage holds its own valid bit and takes a new item whenever it is
// empty or its item moves on, so a stalled receiver only backs up the items
// behind it and bubbles are squeezed out. item_ready drops only when all
// stages are full.
// Reset clears every valid bit and loads the registers with their defaults;
// write registers only while no item is in flight.
module particle_euler_update_top (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    output logic                       item_ready,
    input  pev_pkg::item_t             item,
    output logic                       result_valid,
    input  logic                       result_ready,
    output pev_pkg::result_t           result,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [pev_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import pev_pkg::*;

    cfg_t       cfg;
    work_t      stage_in  [NSTAGE];
    work_t      stage_out [NSTAGE];
    logic       up_valid  [NSTAGE];
    logic       up_ready  [NSTAGE];
    logic       dn_valid  [NSTAGE];
    logic       dn_ready  [NSTAGE];
    logic [8:0] frame_cnt;

    pev_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    for (genvar g = 0; g < NSTAGE; g++)
    begin : g_stage
        if (g == 0)
        begin : g_head
            assign stage_in[g] = front(item, cfg);
            assign up_valid[g] = item_valid;
        end
        else
        begin : g_body
            assign stage_in[g] = stage_op(g, stage_out[g-1], cfg);
            assign up_valid[g] = dn_valid[g-1];
        end

        if (g == NSTAGE - 1)
        begin : g_tail
            assign dn_ready[g] = result_ready;
        end
        else
        begin : g_link
            assign dn_ready[g] = up_ready[g+1];
        end

        pev_pipe u_pipe (
            .clk        (clk),
            .rst_n      (rst_n),
            .up_valid   (up_valid[g]),
            .up_ready   (up_ready[g]),
            .up_data    (stage_in[g]),
            .down_valid (dn_valid[g]),
            .down_ready (dn_ready[g]),
            .down_data  (stage_out[g])
        );
    end

    assign item_ready   = up_ready[0];
    assign result_valid = dn_valid[NSTAGE-1];
    assign result       = to_result(stage_out[NSTAGE-1]);
    assign frame_cnt    = frame_total(cfg);

`ifndef SYNTH
    a_dead_dark: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.active |->
            result.color_red == 8'd0 && result.color_green == 8'd0 &&
            result.color_blue == 8'd0 && result.color_alpha == 8'd0 &&
            result.frame_index == 8'd0)
        else $error("dead particle carries color or frame");

    a_atlas_off: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !cfg.atlas_enable |-> result.frame_index == 8'd0)
        else $error("frame index set with atlas off");

    a_frame_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> 9'(result.frame_index) < frame_cnt)
        else $error("frame index beyond atlas size");
`endif

endmodule
